FILE: src/zdc_pkg.sv
// zdc_pkg: shared types, constants and the byte classifier of the zoned decimal codec
// used by zdc_ctrl, zdc_datapath and zoned_decimal_codec; depends on nothing
`default_nettype none

package zdc_pkg;

    // field sizes
    localparam int MAX_DIGITS   = 18;
    localparam int BCD_DIGITS   = 19;   // enough for the largest 61-bit magnitude seen
    localparam int MAG_W        = 61;
    localparam int ACC_W        = 60;
    localparam int COUNT_W      = 5;
    localparam int SHIFT_CNT_W  = 6;
    localparam int DIGIT_IDX_W  = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int FTYPE_W      = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_TYPE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_COUNT = 1'b1;

    // register reset values
    localparam logic [FTYPE_W-1:0] FIELD_TYPE_RESET  = 2'd1;
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd18;

    // field types
    localparam logic [FTYPE_W-1:0] FT_UNSIGNED  = 2'd0;
    localparam logic [FTYPE_W-1:0] FT_OVERPUNCH = 2'd1;

    // opcodes and result kinds
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;
    localparam logic RK_VALUE  = 1'b0;
    localparam logic RK_BYTE   = 1'b1;

    // character codes
    localparam logic [7:0] CH_DIGIT_ZERO = 8'd48;
    localparam logic [7:0] CH_DIGIT_NINE = 8'd57;
    localparam logic [7:0] CH_POS_ZERO   = 8'd123;
    localparam logic [7:0] CH_NEG_ZERO   = 8'd125;
    localparam logic [7:0] CH_POS_FIRST  = 8'd65;
    localparam logic [7:0] CH_POS_LAST   = 8'd73;
    localparam logic [7:0] CH_NEG_FIRST  = 8'd74;
    localparam logic [7:0] CH_NEG_LAST   = 8'd82;
    localparam logic [7:0] CH_POS_BASE   = 8'd64;
    localparam logic [7:0] CH_NEG_BASE   = 8'd73;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC_FIN,
        ST_ENC_CONV,
        ST_ENC_CHECK,
        ST_ENC_EMIT
    } state_t;

    typedef struct packed {
        logic dec_accept;
        logic dec_finish;
        logic enc_load;
        logic enc_shift;
        logic enc_check;
        logic enc_emit;
    } cmd_t;

    typedef struct packed {
        logic dec_last;
        logic numeric;
        logic conv_done;
        logic emit_last;
        logic slot_free;
    } status_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       ok;
        logic       neg;
    } digit_info_t;

    // digit value and sign of one zoned byte; bad bytes read as zero
    function automatic digit_info_t byte_digit(input logic [7:0] b);
        digit_info_t info;
        logic [7:0]  neg_off;
        neg_off    = b - CH_NEG_BASE;
        info.digit = 4'd0;
        info.ok    = 1'b1;
        info.neg   = 1'b0;
        if (b >= CH_DIGIT_ZERO && b <= CH_DIGIT_NINE)
        begin
            info.digit = b[3:0];
        end
        else if (b == CH_POS_ZERO)
        begin
            info.digit = 4'd0;
        end
        else if (b == CH_NEG_ZERO)
        begin
            info.neg = 1'b1;
        end
        else if (b >= CH_POS_FIRST && b <= CH_POS_LAST)
        begin
            info.digit = b[3:0];
        end
        else if (b >= CH_NEG_FIRST && b <= CH_NEG_LAST)
        begin
            info.digit = neg_off[3:0];
            info.neg   = 1'b1;
        end
        else
        begin
            info.ok = 1'b0;
        end
        return info;
    endfunction

endpackage

`default_nettype wire

FILE: src/zdc_ctrl.sv
// zdc_ctrl: sequencing state machine of the zoned decimal codec
// depends on zdc_pkg; drives the datapath through cmd_t, watches status_t
`default_nettype none

module zdc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             opcode,
    output logic                  in_ready,
    input  wire zdc_pkg::status_t sts,
    output zdc_pkg::cmd_t         cmd
);

    zdc_pkg::state_t state_reg;
    zdc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= zdc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            zdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode == zdc_pkg::OP_DECODE)
                    begin
                        cmd.dec_accept = 1'b1;
                        if (sts.dec_last)
                            state_next = zdc_pkg::ST_DEC_FIN;
                    end
                    else if (sts.numeric)
                    begin
                        cmd.enc_load = 1'b1;
                        state_next   = zdc_pkg::ST_ENC_CONV;
                    end
                end
            end
            zdc_pkg::ST_DEC_FIN:
            begin
                if (sts.slot_free)
                begin
                    cmd.dec_finish = 1'b1;
                    state_next     = zdc_pkg::ST_IDLE;
                end
            end
            zdc_pkg::ST_ENC_CONV:
            begin
                cmd.enc_shift = 1'b1;
                if (sts.conv_done)
                    state_next = zdc_pkg::ST_ENC_CHECK;
            end
            zdc_pkg::ST_ENC_CHECK:
            begin
                cmd.enc_check = 1'b1;
                state_next    = zdc_pkg::ST_ENC_EMIT;
            end
            zdc_pkg::ST_ENC_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.enc_emit = 1'b1;
                    if (sts.emit_last)
                        state_next = zdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zdc_pkg::ST_IDLE;
            end
        endcase
    end

    // the digit check always follows the last conversion shift
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == zdc_pkg::ST_ENC_CHECK |-> $past(state_reg) == zdc_pkg::ST_ENC_CONV)
        else $error("digit check entered without conversion");

    // a finished decode waits while the output slot is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == zdc_pkg::ST_DEC_FIN && !sts.slot_free) |=> state_reg == zdc_pkg::ST_DEC_FIN)
        else $error("decode result dropped on stall");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.dec_accept, cmd.dec_finish, cmd.enc_load,
                  cmd.enc_shift, cmd.enc_check, cmd.enc_emit}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: src/zdc_datapath.sv
// zdc_datapath: config registers, decode accumulator, binary to bcd converter, output register
// depends on zdc_pkg; commanded by zdc_ctrl
`default_nettype none

module zdc_datapath #(
    parameter int MAX_DIGITS = zdc_pkg::MAX_DIGITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [zdc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [zdc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic [7:0]                            in_byte,
    input  wire logic signed [zdc_pkg::MAG_W-1:0]      in_value,
    input  wire zdc_pkg::cmd_t                         cmd,
    output zdc_pkg::status_t                           sts,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       result_kind,
    output logic signed [zdc_pkg::MAG_W-1:0]           out_value,
    output logic [7:0]                                 out_byte,
    output logic                                       last_of_run,
    output logic                                       overflow,
    output logic                                       bad_digit
);

    localparam int MAG_W   = zdc_pkg::MAG_W;
    localparam int ACC_W   = zdc_pkg::ACC_W;
    localparam int CNT_W   = zdc_pkg::COUNT_W;
    localparam int NDIG    = zdc_pkg::BCD_DIGITS;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_DIGITS);

    // configuration
    logic [zdc_pkg::FTYPE_W-1:0] field_type_reg;
    logic [CNT_W-1:0]            digit_count_reg;

    // decode state
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic             negative_reg;
    logic             bad_reg;

    // encode state
    logic [MAG_W-1:0]                    mag_reg;
    logic [NDIG-1:0][3:0]                bcd_reg;
    logic                                enc_neg_reg;
    logic [zdc_pkg::SHIFT_CNT_W-1:0]     shift_cnt_reg;
    logic                                ovf_reg;
    logic [zdc_pkg::DIGIT_IDX_W-1:0]     digit_idx_reg;

    // output slot
    logic                     out_valid_reg;
    logic                     result_kind_reg;
    logic signed [MAG_W-1:0]  out_value_reg;
    logic [7:0]               out_byte_reg;
    logic                     last_reg;
    logic                     ovf_out_reg;
    logic                     bad_out_reg;

    logic                  numeric;
    logic [CNT_W-1:0]      eff_n;
    logic [CNT_W-1:0]      count_inc;
    zdc_pkg::digit_info_t  info;
    logic [ACC_W-1:0]      acc_mac;
    logic [MAG_W-1:0]      dec_value;
    logic [MAG_W-1:0]      in_raw;
    logic [MAG_W-1:0]      in_mag;
    logic [NDIG-1:0][3:0]  bcd_adj;
    logic [NDIG-1:0][3:0]  bcd_shift;
    logic                  ovf_any;
    logic [3:0]            emit_digit;
    logic [7:0]            emit_byte;
    logic                  slot_free;

    assign numeric   = (field_type_reg == zdc_pkg::FT_UNSIGNED) ||
                       (field_type_reg == zdc_pkg::FT_OVERPUNCH);
    assign count_inc = byte_count_reg + CNT_W'(1);
    assign info      = zdc_pkg::byte_digit(in_byte);
    assign acc_mac   = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                       + {{(ACC_W-4){1'b0}}, info.digit};
    assign in_raw    = MAG_W'(in_value);
    assign in_mag    = in_raw[MAG_W-1] ? (MAG_W'(0) - in_raw) : in_raw;
    assign slot_free = !out_valid_reg || out_ready;

    // clamp of the digit count
    always_comb
    begin
        if (digit_count_reg == '0)
            eff_n = CNT_W'(1);
        else if (digit_count_reg > MAX_N)
            eff_n = MAX_N;
        else
            eff_n = digit_count_reg;
    end

    // sign applied to the accumulated magnitude
    always_comb
    begin
        if (!numeric)
            dec_value = '0;
        else if (negative_reg)
            dec_value = MAG_W'(0) - {1'b0, acc_reg};
        else
            dec_value = {1'b0, acc_reg};
    end

    // double dabble step and high digit check
    always_comb
    begin
        ovf_any = 1'b0;
        for (int k = 0; k < NDIG; k++)
        begin
            bcd_adj[k] = (bcd_reg[k] >= 4'd5) ? bcd_reg[k] + 4'd3 : bcd_reg[k];
            if (k >= int'(eff_n) && bcd_reg[k] != 4'd0)
                ovf_any = 1'b1;
        end
        bcd_shift[0] = {bcd_adj[0][2:0], mag_reg[MAG_W-1]};
        for (int k = 1; k < NDIG; k++)
            bcd_shift[k] = {bcd_adj[k][2:0], bcd_adj[k-1][3]};
    end

    // text byte for the current digit, overpunched on the last one when field_type is overpunch
    always_comb
    begin
        emit_digit = bcd_reg[digit_idx_reg];
        if (digit_idx_reg == '0 && field_type_reg == zdc_pkg::FT_OVERPUNCH)
        begin
            if (emit_digit == 4'd0)
                emit_byte = enc_neg_reg ? zdc_pkg::CH_NEG_ZERO : zdc_pkg::CH_POS_ZERO;
            else
                emit_byte = {4'd0, emit_digit}
                            + (enc_neg_reg ? zdc_pkg::CH_NEG_BASE : zdc_pkg::CH_POS_BASE);
        end
        else
        begin
            emit_byte = {4'd0, emit_digit} + zdc_pkg::CH_DIGIT_ZERO;
        end
    end

    always_comb
    begin
        sts.dec_last  = count_inc >= eff_n;
        sts.numeric   = numeric;
        sts.conv_done = shift_cnt_reg == zdc_pkg::SHIFT_CNT_W'(1);
        sts.emit_last = digit_idx_reg == '0;
        sts.slot_free = slot_free;
    end

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_type_reg  <= zdc_pkg::FIELD_TYPE_RESET;
            digit_count_reg <= zdc_pkg::DIGIT_COUNT_RESET;
            acc_reg         <= '0;
            byte_count_reg  <= '0;
            negative_reg    <= 1'b0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    zdc_pkg::CFG_FIELD_TYPE:  field_type_reg  <= cfg_data[zdc_pkg::FTYPE_W-1:0];
                    zdc_pkg::CFG_DIGIT_COUNT: digit_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.dec_accept)
            begin
                byte_count_reg <= count_inc;
                if (numeric)
                begin
                    acc_reg <= acc_mac;
                    if (!info.ok)
                        bad_reg <= 1'b1;
                    if (count_inc >= eff_n)
                        negative_reg <= info.neg;
                end
            end
            else if (cmd.dec_finish)
            begin
                acc_reg        <= '0;
                byte_count_reg <= '0;
                negative_reg   <= 1'b0;
                bad_reg        <= 1'b0;
            end
            if (cmd.dec_finish || cmd.enc_emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // encode payload and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.enc_load)
        begin
            mag_reg       <= in_mag;
            enc_neg_reg   <= in_raw[MAG_W-1];
            bcd_reg       <= '0;
            shift_cnt_reg <= zdc_pkg::SHIFT_CNT_W'(MAG_W);
        end
        else if (cmd.enc_shift)
        begin
            mag_reg       <= {mag_reg[MAG_W-2:0], 1'b0};
            bcd_reg       <= bcd_shift;
            shift_cnt_reg <= shift_cnt_reg - zdc_pkg::SHIFT_CNT_W'(1);
        end
        if (cmd.enc_check)
        begin
            ovf_reg       <= ovf_any;
            digit_idx_reg <= zdc_pkg::DIGIT_IDX_W'(eff_n - CNT_W'(1));
        end
        else if (cmd.enc_emit)
        begin
            digit_idx_reg <= digit_idx_reg - zdc_pkg::DIGIT_IDX_W'(1);
        end
        if (cmd.dec_finish)
        begin
            result_kind_reg <= zdc_pkg::RK_VALUE;
            out_value_reg   <= dec_value;
            out_byte_reg    <= 8'd0;
            last_reg        <= 1'b0;
            ovf_out_reg     <= 1'b0;
            bad_out_reg     <= numeric && bad_reg;
        end
        else if (cmd.enc_emit)
        begin
            result_kind_reg <= zdc_pkg::RK_BYTE;
            out_value_reg   <= '0;
            out_byte_reg    <= emit_byte;
            last_reg        <= digit_idx_reg == '0;
            ovf_out_reg     <= ovf_reg;
            bad_out_reg     <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign out_value   = out_value_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign overflow    = ovf_out_reg;
    assign bad_digit   = bad_out_reg;

    // a field never runs past the largest digit count
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_N)
        else $error("decode byte count past field size");

    // the first digit to emit lies inside the field
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enc_check |=> digit_idx_reg < MAX_N)
        else $error("digit index outside field");

endmodule

`default_nettype wire

FILE: src/zoned_decimal_codec.sv
// zoned_decimal_codec: top level of the zoned decimal / binary converter
// depends on zdc_pkg, zdc_ctrl and zdc_datapath
//
// usage
//   input channel (in_valid/in_ready) carries opcode, in_byte and in_value.
//   a decode beat feeds one text byte, most significant first; after
//   digit_count bytes one value beat leaves on the output channel
//   (out_valid/out_ready) with the signed value and bad_digit.
//   an encode beat takes in_value and sends digit_count byte beats,
//   most significant first, last_of_run on the final one, overflow on all
//   when the magnitude has more digits than the field.
//   non-final decode bytes give no beat; the final one moves the sequencer to
//   its finish state, which registers the value beat when the output register
//   is free. an encode loads in_value, the bcd converter shifts one magnitude
//   bit per cycle, digits are checked, then one digit leaves per cycle
//   unless stalled. in_ready stays low until the last byte is loaded.
//   field_type 2 makes encode accept the beat and send nothing.
//   reset clears the partial decode field, empties the output register and
//   loads field_type 1 and digit_count 18.
//   when the receiver stalls, the pending beat holds in the output register
//   and the sequencer waits; nothing is dropped.
//   cfg_write with cfg_index and cfg_data writes a register with no wait.
`default_nettype none

module zoned_decimal_codec #(
    parameter int MAX_DIGITS = zdc_pkg::MAX_DIGITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_write,
    input  wire logic [zdc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [zdc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  opcode,
    input  wire logic [7:0]                            in_byte,
    input  wire logic signed [zdc_pkg::MAG_W-1:0]      in_value,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       result_kind,
    output logic signed [zdc_pkg::MAG_W-1:0]           out_value,
    output logic [7:0]                                 out_byte,
    output logic                                       last_of_run,
    output logic                                       overflow,
    output logic                                       bad_digit
);

    // commands from the sequencer, status back from the datapath
    zdc_pkg::cmd_t    cmd;
    zdc_pkg::status_t sts;

    zdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    zdc_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_byte     (in_byte),
        .in_value    (in_value),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_value   (out_value),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .overflow    (overflow),
        .bad_digit   (bad_digit)
    );

endmodule

`default_nettype wire
